>>> sv/utf8_validating_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property shapes for the decoder's port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UTF8V_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define UTF8V_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder: next-cycle check failed");

`endif

>>> sv/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared widths, constants, queue entry types and the sequence judge.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int CP_W       = 21;
  localparam int QDEPTH_DEF = 4;

  localparam logic [CP_W-1:0] REPL_CP      = 21'h00fffd;
  localparam logic [CP_W-1:0] NONCHAR_LO   = 21'h00fdd0;
  localparam logic [CP_W-1:0] NONCHAR_HI   = 21'h00fdef;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00d800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00dfff;
  localparam logic [CP_W-1:0] MAX_1BYTE    = 21'h00007f;
  localparam logic [CP_W-1:0] MAX_2BYTE    = 21'h0007ff;
  localparam logic [CP_W-1:0] MAX_3BYTE    = 21'h00ffff;
  localparam logic [15:0]     LOW_FFFF     = 16'hffff;
  localparam logic [15:0]     LOW_FFFE     = 16'hfffe;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            valid_res;
  } res_t;

  // One queue entry: the results that one byte causes (one or two)
  typedef struct packed {
    logic pair;
    res_t first;
    res_t second;
  } qent_t;

  // Judge a closed sequence: value, tail count asked for, tail count seen
  function automatic res_t judge_seq(input logic [CP_W-1:0] v,
                                     input logic [2:0]      exp_tail,
                                     input logic [2:0]      seen);
    logic       ok;
    logic [2:0] need;
    res_t       r;
    if (v <= MAX_1BYTE)      need = 3'd0;
    else if (v <= MAX_2BYTE) need = 3'd1;
    else if (v <= MAX_3BYTE) need = 3'd2;
    else                     need = 3'd3;
    ok = (seen == exp_tail) && (exp_tail <= 3'd3)
         && (v[15:0] != LOW_FFFF) && (v[15:0] != LOW_FFFE)
         && !((v >= NONCHAR_LO) && (v <= NONCHAR_HI))
         && !((v >= SURR_LO) && (v <= SURR_HI))
         && ((v == '0) || (need == exp_tail));
    r.code_point = ok ? v : REPL_CP;
    r.valid_res  = ok;
    return r;
  endfunction

endpackage

>>> sv/utf8_validating_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder, top level
// Byte-in, code-point-out decoder with a front end, result queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one UTF-8 byte per beat with an
//   end-of-text flag. Output channel (out_valid / out_stall): one decoded
//   code point per beat, with valid_res (0 means U+FFFD replacement) and
//   last_of_run on the final result caused by an input byte.
//   Throughput: one byte per cycle while in_stall is low. A byte causes
//   zero, one or two results; the output register issues one result per
//   cycle while out_stall is low, so a byte that closes a sequence and also
//   gives a result of its own leaves two result beats. The queue is written
//   at the edge that accepts the input beat, and the back-end output
//   register then loads the entry from the queue.
//   The queue (QDEPTH entries) sets how long the input keeps flowing while the
//   receiver stalls; in_stall rises only when the queue is full.
//   Reset: synchronous, active low; no sequence open, queue and output empty.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_top #(
  parameter int QDEPTH = utf8v_pkg::QDEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_req,
  input  logic                       in_end_of_text,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [utf8v_pkg::CP_W-1:0] out_code_point,
  output logic                       out_valid_res,
  output logic                       out_last_of_run
);
  import utf8v_pkg::*;

  logic  q_full;
  logic  q_push;
  qent_t q_data;
  logic  q_valid;
  logic  q_pop;
  qent_t q_head;

  utf8v_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  utf8v_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  utf8v_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_valid_res   (out_valid_res),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> sv/utf8v_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the open sequence and classifies each byte into the
// zero, one or two results it causes, pushed as one queue entry.
// ----------------------------------------------------------------------------
module utf8v_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte_req,
  input  logic           in_end_of_text,
  input  logic           q_full,
  output logic           q_push,
  output utf8v_pkg::qent_t q_data
);
  import utf8v_pkg::*;

  logic            collecting_r, collecting_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [2:0]      seen_r, seen_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;

  logic            accept;
  logic            cont;
  logic [CP_W-1:0] absorbed;
  logic [2:0]      seen_inc;
  logic [2:0]      lead_tail;
  logic [7:0]      lead_mask;
  res_t            close_res;
  res_t            fresh_res;
  logic            fresh_has;
  logic            any_res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cont     = (in_byte_req[7:6] == 2'b10);
  assign absorbed = {partial_r[CP_W-7:0], in_byte_req[5:0]};
  assign seen_inc = (seen_r == 3'd7) ? seen_r : seen_r + 3'd1;

  // Decode lead byte length and payload mask
  always_comb begin
    if (in_byte_req <= 8'hdf) begin
      lead_tail = 3'd1; lead_mask = 8'h1f;
    end else if (in_byte_req <= 8'hef) begin
      lead_tail = 3'd2; lead_mask = 8'h0f;
    end else if (in_byte_req <= 8'hf7) begin
      lead_tail = 3'd3; lead_mask = 8'h07;
    end else if (in_byte_req <= 8'hfb) begin
      lead_tail = 3'd4; lead_mask = 8'h03;
    end else begin
      lead_tail = 3'd5; lead_mask = 8'h03;
    end
  end

  // Judge the sequence that closes on this byte
  always_comb begin
    if (cont) close_res = judge_seq(absorbed, exp_r, seen_inc);
    else      close_res = judge_seq(partial_r, exp_r, seen_r);
  end

  // Classify the byte and build the next state and the queue entry
  always_comb begin
    collecting_nxt = collecting_r;
    exp_nxt        = exp_r;
    seen_nxt       = seen_r;
    partial_nxt    = partial_r;
    fresh_res.code_point = REPL_CP;
    fresh_res.valid_res  = 1'b0;
    fresh_has      = 1'b1;
    if (collecting_r && cont) begin
      // absorb continuation; close only at end of text
      fresh_has   = 1'b0;
      seen_nxt    = seen_inc;
      partial_nxt = absorbed;
      if (in_end_of_text) begin
        collecting_nxt = 1'b0;
        exp_nxt        = '0;
        seen_nxt       = '0;
        partial_nxt    = '0;
      end
    end else begin
      collecting_nxt = 1'b0;
      exp_nxt        = '0;
      seen_nxt       = '0;
      partial_nxt    = '0;
      if (!in_byte_req[7]) begin
        fresh_res.code_point = {{(CP_W-8){1'b0}}, in_byte_req};
        fresh_res.valid_res  = 1'b1;
      end else if (!cont) begin
        // lead byte opens a sequence; at end of text it closes empty and fails
        if (!in_end_of_text) begin
          fresh_has      = 1'b0;
          collecting_nxt = 1'b1;
          exp_nxt        = lead_tail;
          partial_nxt    = {{(CP_W-8){1'b0}}, in_byte_req & lead_mask};
        end
      end
    end
  end

  // Pack results: a closing sequence goes first, the fresh byte second
  always_comb begin
    q_data.pair   = 1'b0;
    q_data.first  = fresh_res;
    q_data.second = fresh_res;
    any_res       = fresh_has;
    if (collecting_r && cont) begin
      q_data.first = close_res;
      any_res      = in_end_of_text;
    end else if (collecting_r) begin
      q_data.first = close_res;
      q_data.pair  = fresh_has;
      any_res      = 1'b1;
    end
  end

  assign q_push = accept && any_res;

  // Advance sequence state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      exp_r        <= '0;
      seen_r       <= '0;
      partial_r    <= '0;
    end else if (accept) begin
      collecting_r <= collecting_nxt;
      exp_r        <= exp_nxt;
      seen_r       <= seen_nxt;
      partial_r    <= partial_nxt;
    end
  end

endmodule

>>> sv/utf8v_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Short circular queue of result entries between front and back end.
// ----------------------------------------------------------------------------
module utf8v_queue #(
  parameter int QDEPTH = utf8v_pkg::QDEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  input  utf8v_pkg::qent_t q_data,
  output logic             q_full,
  output logic             q_valid,
  input  logic             q_pop,
  output utf8v_pkg::qent_t q_head
);
  import utf8v_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t             mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_full  = (count_r == CNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = mem[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && q_valid;

  // Wrap pointers and track fill
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_data;
    end
  end

endmodule

>>> sv/utf8v_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Pops queue entries and issues their results one beat at a time from an
// output register, marking the final result of each byte.
// ----------------------------------------------------------------------------
module utf8v_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  utf8v_pkg::qent_t             q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [utf8v_pkg::CP_W-1:0]   out_code_point,
  output logic                         out_valid_res,
  output logic                         out_last_of_run
);
  import utf8v_pkg::*;

  logic            out_valid_r, out_valid_nxt;
  logic            phase_r, phase_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            ok_r, ok_nxt;
  logic            last_r, last_nxt;
  res_t            held_r, held_nxt;
  logic            load;

  // Output register is free when empty or being taken
  assign load  = !out_valid_r || !out_stall;
  assign q_pop = load && !phase_r && q_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    cp_nxt        = cp_r;
    ok_nxt        = ok_r;
    last_nxt      = last_r;
    held_nxt      = held_r;
    if (load) begin
      if (phase_r) begin
        // issue the held second result
        out_valid_nxt = 1'b1;
        cp_nxt        = held_r.code_point;
        ok_nxt        = held_r.valid_res;
        last_nxt      = 1'b1;
        phase_nxt     = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        cp_nxt        = q_head.first.code_point;
        ok_nxt        = q_head.first.valid_res;
        last_nxt      = !q_head.pair;
        held_nxt      = q_head.second;
        phase_nxt     = q_head.pair;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    ok_r   <= ok_nxt;
    last_r <= last_nxt;
    held_r <= held_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_valid_res   = ok_r;
  assign out_last_of_run = last_r;

endmodule

>>> sv/utf8v_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the top-level ports for output handshake and result sanity.
// ----------------------------------------------------------------------------
`include "utf8_validating_decoder_top_assert.svh"

module utf8v_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [utf8v_pkg::CP_W-1:0] out_code_point,
  input logic                       out_valid_res,
  input logic                       out_last_of_run
);
  import utf8v_pkg::*;

  logic [CP_W+1:0] out_beat;

  assign out_beat = {out_code_point, out_valid_res, out_last_of_run};

  // Hold a stalled result beat
  `UTF8V_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `UTF8V_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_beat))

  // Rejected results carry the replacement character
  `UTF8V_ASSERT_NOW(a_reject_repl, out_valid && !out_valid_res, out_code_point == REPL_CP)

  // Accepted results never land on a surrogate
  `UTF8V_ASSERT_NOW(a_no_surrogate, out_valid && out_valid_res, (out_code_point < SURR_LO) || (out_code_point > SURR_HI))

endmodule

bind utf8_validating_decoder_top utf8v_checker u_utf8v_checker (.*);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder testbench
// Drives a byte stream into the decoder, with random idle gaps on the input
// side and random stalls on the output side. A scoreboard tracks the open
// sequence from every accepted byte and predicts the code points, accept
// flags and last-of-run markers. It checks each output beat, in order,
// against the oldest prediction.
// ----------------------------------------------------------------------------

class utf8_scoreboard;

  typedef struct packed {
    logic [utf8v_pkg::CP_W-1:0] cp;
    logic                       ok;
    logic                       last;
  } cp_beat_t;

  cp_beat_t                   expected_q[$];
  bit                         open_seq;
  bit [2:0]                   want_tail;
  bit [2:0]                   tail_seen;
  logic [utf8v_pkg::CP_W-1:0] acc;
  int                         errors;
  int                         checked;
  int                         accepted_cnt;
  int                         replaced_cnt;

  function new();
    open_seq  = 1'b0;
    want_tail = '0;
    tail_seen = '0;
    acc       = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Judge the open sequence, then close it
  function cp_beat_t close_seq();
    logic [utf8v_pkg::CP_W-1:0] v;
    bit [2:0]                   shortest;
    bit                         good;
    cp_beat_t                   r;
    v    = acc;
    good = 1'b1;
    if (tail_seen != want_tail) begin
      good = 1'b0;
    end else if (want_tail > 3'd3) begin
      good = 1'b0;
    end else if (v[15:0] == utf8v_pkg::LOW_FFFF || v[15:0] == utf8v_pkg::LOW_FFFE) begin
      good = 1'b0;
    end else if (v >= utf8v_pkg::NONCHAR_LO && v <= utf8v_pkg::NONCHAR_HI) begin
      good = 1'b0;
    end else if (v >= utf8v_pkg::SURR_LO && v <= utf8v_pkg::SURR_HI) begin
      good = 1'b0;
    end else if (v != '0) begin
      // Nonzero values must use their shortest form; an overlong zero passes
      if (v <= utf8v_pkg::MAX_1BYTE) shortest = 3'd0;
      else if (v <= utf8v_pkg::MAX_2BYTE) shortest = 3'd1;
      else if (v <= utf8v_pkg::MAX_3BYTE) shortest = 3'd2;
      else shortest = 3'd3;
      if (shortest != want_tail) good = 1'b0;
    end
    open_seq  = 1'b0;
    want_tail = '0;
    tail_seen = '0;
    acc       = '0;
    r.cp   = good ? v : utf8v_pkg::REPL_CP;
    r.ok   = good;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the decoder state by one accepted byte and queue its results
  function void note_byte(logic [7:0] b, logic eot);
    cp_beat_t step_res[2];
    int       n;
    bit       is_cont;
    n       = 0;
    is_cont = (b[7:6] == 2'b10);
    if (open_seq && is_cont) begin
      acc = {acc[14:0], b[5:0]};
      if (tail_seen != 3'd7) tail_seen = tail_seen + 3'd1;
      if (eot) begin
        step_res[n] = close_seq();
        n++;
      end
    end else begin
      if (open_seq) begin
        step_res[n] = close_seq();
        n++;
      end
      if (!b[7]) begin
        step_res[n] = '{cp: {13'd0, b}, ok: 1'b1, last: 1'b0};
        n++;
      end else if (is_cont) begin
        step_res[n] = '{cp: utf8v_pkg::REPL_CP, ok: 1'b0, last: 1'b0};
        n++;
      end else begin
        // Open a sequence from the lead byte
        open_seq  = 1'b1;
        tail_seen = '0;
        if (b <= 8'hDF) begin
          want_tail = 3'd1;
          acc       = {16'd0, b[4:0]};
        end else if (b <= 8'hEF) begin
          want_tail = 3'd2;
          acc       = {17'd0, b[3:0]};
        end else if (b <= 8'hF7) begin
          want_tail = 3'd3;
          acc       = {18'd0, b[2:0]};
        end else if (b <= 8'hFB) begin
          want_tail = 3'd4;
          acc       = {19'd0, b[1:0]};
        end else begin
          want_tail = 3'd5;
          acc       = {19'd0, b[1:0]};
        end
        if (eot) begin
          step_res[n] = close_seq();
          n++;
        end
      end
    end
    if (n > 0) step_res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(step_res[i]);
  endfunction

  // Compare one output beat with the oldest prediction
  function void check_result(logic [utf8v_pkg::CP_W-1:0] cp, logic ok, logic last);
    cp_beat_t want;
    checked++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 20)
        $display("%0t: unexpected result, got code_point %h valid_res %b last_of_run %b",
                 $time, cp, ok, last);
      return;
    end
    want = expected_q.pop_front();
    if (want.ok) accepted_cnt++;
    else replaced_cnt++;
    if (cp !== want.cp || ok !== want.ok || last !== want.last) begin
      errors++;
      if (errors <= 20) begin
        if (cp !== want.cp)
          $display("%0t: code_point expected %h, got %h", $time, want.cp, cp);
        if (ok !== want.ok)
          $display("%0t: valid_res expected %b, got %b", $time, want.ok, ok);
        if (last !== want.last)
          $display("%0t: last_of_run expected %b, got %b", $time, want.last, last);
      end
    end
  endfunction

endclass

module testbench;

  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT   = 1000;
  localparam int NUM_DIRECTED = 26;

  // Directed bytes as {end_of_text, byte}
  localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
    9'h000, 9'h07F,                   // ASCII extremes
    9'h0BF,                           // stray continuation
    9'h0C3, 9'h0A9,                   // two-byte form
    9'h0E2, 9'h082, 9'h0AC,           // three-byte form
    9'h0F0, 9'h09F, 9'h098, 9'h080,   // four-byte form
    9'h0C0, 9'h080,                   // overlong zero
    9'h0ED, 9'h0A0, 9'h080,           // surrogate
    9'h0E2, 9'h082, 9'h041,           // short sequence closed by ASCII
    9'h1C2,                           // lead byte at end of text
    9'h0FC, 9'h180,                   // six-byte lead, closed by end of text
    9'h0FF, 9'h080, 9'h141            // lead FF (taken as six-byte form) closed by ASCII at end
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_byte_req = 8'h00;
  logic                       in_end_of_text = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [utf8v_pkg::CP_W-1:0] out_code_point;
  logic                       out_valid_res;
  logic                       out_last_of_run;

  utf8_scoreboard sb = new();

  int items_sent   = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int phase_cnt    = 0;
  bit in_calm      = 1'b0;
  bit out_calm     = 1'b0;

  utf8_validating_decoder_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_req     (in_byte_req),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_valid_res   (out_valid_res),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  // Mostly short idle stretches, a few long ones
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (in_calm || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  // Switch between calm and busy stretches on each side
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1;
    if (phase_cnt % 256 == 255) begin
      in_calm  <= ($urandom_range(0, 3) == 0);
      out_calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // Drive receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_calm || $urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left <= idle_len() - 1;
    end
  end

  // Check every output beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_code_point, out_valid_res, out_last_of_run);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Send one byte and hold it until accepted
  task automatic put_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_req    <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, eot);
    items_sent++;
  endtask

  // Hold off the input until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Pick a value that lands near the interesting ranges for a given tail
  function automatic logic [20:0] pick_value(input int tail);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 21'($urandom_range(32'hD800, 32'hDFFF));
      1: return 21'($urandom_range(32'hFDD0, 32'hFDEF));
      2: return {5'($urandom), 15'h7FFF, 1'($urandom)};
      3: return ($urandom_range(0, 3) == 0) ? 21'd0 : 21'($urandom_range(1, 32'h7F));
      4: begin
        case ($urandom_range(0, 7))
          0: return 21'h00007F;
          1: return 21'h000080;
          2: return 21'h0007FF;
          3: return 21'h000800;
          4: return 21'h00FFFF;
          5: return 21'h010000;
          6: return 21'h10FFFF;
          default: return 21'h1FFFFF;
        endcase
      end
      default: begin
        case (tail)
          1: return 21'($urandom_range(32'h80, 32'h7FF));
          2: return 21'($urandom_range(32'h800, 32'hFFFF));
          3: return 21'($urandom_range(32'h10000, 32'h1FFFFF));
          default: return 21'($urandom);
        endcase
      end
    endcase
  endfunction

  // Encode a value as a lead byte plus n_cont continuation bytes
  task automatic put_sequence(input int tail, input int n_cont, input logic [20:0] v,
                              input bit eot_at_end);
    logic [7:0]  lead;
    logic [20:0] sh;
    logic [5:0]  bits;
    int          idx;
    case (tail)
      1: lead = {3'b110, v[10:6]};
      2: lead = {4'b1110, v[15:12]};
      3: lead = {5'b11110, v[20:18]};
      4: lead = {6'b111110, 2'($urandom)};
      default: lead = {6'b111111, 2'($urandom)};
    endcase
    put_byte(lead, eot_at_end && n_cont == 0);
    for (int i = 0; i < n_cont; i++) begin
      idx = tail - 1 - i;
      if (idx >= 0 && idx <= 3) begin
        sh   = v >> (6 * idx);
        bits = sh[5:0];
      end else begin
        bits = 6'($urandom);
      end
      put_byte({2'b10, bits}, eot_at_end && i == n_cont - 1);
    end
  endtask

  initial begin
    int  r;
    int  tail;
    int  n_cont;
    bit  paused;
    paused = 1'b0;

    // Hold reset, then release
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes
    for (int i = 0; i < NUM_DIRECTED; i++) put_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    // Random stream, mostly well-formed sequences with random content
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        put_byte(8'($urandom_range(0, 127)), $urandom_range(0, 19) == 0);
      end else if (r < 30) begin
        put_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end else if (r < 35) begin
        // Long run of continuations, which can saturate the seen count
        put_sequence($urandom_range(1, 5), $urandom_range(6, 10), 21'($urandom),
                     $urandom_range(0, 3) == 0);
      end else begin
        tail   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
        n_cont = tail;
        if ($urandom_range(0, 99) < 12) n_cont = ($urandom_range(0, 1) == 0) ? tail - 1 : tail + 1;
        put_sequence(tail, n_cont, pick_value(tail), $urandom_range(0, 7) == 0);
      end
      if (!paused && items_sent >= NUM_DIRECTED + RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    // Drain and let any stray late beats show up
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes (%0d directed); checked %0d code points: %0d accepted, %0d replaced.",
             items_sent, NUM_DIRECTED, sb.checked, sb.accepted_cnt, sb.replaced_cnt);
    $display("Mismatches or unexpected beats: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/utf8v_pkg.sv
sv/utf8v_front.sv
sv/utf8v_queue.sv
sv/utf8v_back.sv
sv/utf8_validating_decoder_top.sv
sv/utf8v_checker.sv
verif/testbench.sv
